// ===== hdl/z80sbd_pkg.sv =====
package z80sbd_pkg;

    // Field widths fixed by the interface.
    localparam int ADDR_W     = 17;
    localparam int DATA_W     = 8;
    localparam int CNT_W      = 8;
    localparam int LEN_W      = 16;
    localparam int CONS_W     = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;
    localparam int PAGE_NUM_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COMPRESSED  = 1'b1;

    // Format modes; the spare code behaves as the 128K map.
    localparam logic [1:0] FMT_SINGLE   = 2'd0;
    localparam logic [1:0] FMT_PAGED48  = 2'd1;
    localparam logic [1:0] FMT_PAGED128 = 2'd2;

    // Stream markers.
    localparam logic [DATA_W-1:0] ESC_BYTE = 8'hED;
    localparam logic [LEN_W-1:0]  RAW_MARK = 16'hFFFF;

    // Load addresses.
    localparam logic [ADDR_W-1:0] SINGLE_BASE = 17'h04000;
    localparam logic [ADDR_W-1:0] MAP48_BASE4 = 17'h08000;
    localparam logic [ADDR_W-1:0] MAP48_BASE5 = 17'h0C000;
    localparam logic [ADDR_W-1:0] MAP48_BASE8 = 17'h04000;

    // Page numbers that carry a mapping.
    localparam logic [PAGE_NUM_W-1:0] MAP48_PAGE4   = 8'd4;
    localparam logic [PAGE_NUM_W-1:0] MAP48_PAGE5   = 8'd5;
    localparam logic [PAGE_NUM_W-1:0] MAP48_PAGE8   = 8'd8;
    localparam logic [PAGE_NUM_W-1:0] MAP128_FIRST  = 8'd3;
    localparam logic [PAGE_NUM_W-1:0] MAP128_LAST   = 8'd10;

    // Block header sequencer.
    typedef enum logic [1:0] {
        HDR_LEN_LO,
        HDR_LEN_HI,
        HDR_PAGE,
        HDR_DATA
    } hdr_phase_t;

    // Run escape sequencer: first ED seen, second ED seen, count held.
    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_ONE,
        ESC_TWO,
        ESC_VALUE
    } esc_phase_t;

    // One memory fill.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] value;
        logic [CNT_W-1:0]  count;
    } fill_t;

    // The fills caused by one input byte.
    typedef struct packed {
        fill_t lo;
        fill_t hi;
        logic  two;
    } fill_pair_t;

endpackage

// ===== hdl/z80sbd_decode.sv =====
module z80sbd_decode #(
    parameter int PAGE_BYTES         = 16384,
    parameter int SINGLE_BLOCK_BYTES = 49152
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [1:0]                          format_mode,
    input  logic                                compressed,
    input  logic                                accept,
    input  logic [z80sbd_pkg::DATA_W-1:0]       data_byte,
    input  logic                                start_req,
    output logic                                res_valid,
    output z80sbd_pkg::fill_pair_t              res
);

    localparam int LEN_MAX = (PAGE_BYTES > SINGLE_BLOCK_BYTES) ? PAGE_BYTES
                                                               : SINGLE_BLOCK_BYTES;
    localparam int OFF_W = $clog2(LEN_MAX + 1);
    localparam logic [OFF_W-1:0] PAGE_LEN   = OFF_W'(PAGE_BYTES);
    localparam logic [OFF_W-1:0] SINGLE_LEN = OFF_W'(SINGLE_BLOCK_BYTES);
    localparam logic [z80sbd_pkg::ADDR_W-1:0] PAGE_STEP =
        z80sbd_pkg::ADDR_W'(PAGE_BYTES);
    localparam logic [z80sbd_pkg::CONS_W-1:0] RAW_LEN =
        z80sbd_pkg::CONS_W'(PAGE_BYTES);

    // Decoding state.
    z80sbd_pkg::hdr_phase_t               hdr_reg, hdr_cur, hdr_next;
    z80sbd_pkg::esc_phase_t               esc_reg, esc_cur, esc_dec, esc_next;
    logic [z80sbd_pkg::LEN_W-1:0]         blen_reg, blen_cur, blen_next;
    logic [z80sbd_pkg::PAGE_NUM_W-1:0]    page_reg, page_cur, page_next;
    logic [z80sbd_pkg::CONS_W-1:0]        cons_reg, cons_cur, cons_next, cons_inc, eff_len;
    logic [OFF_W-1:0]                     off_reg, off_cur, off_dec, off_next;
    logic [z80sbd_pkg::CNT_W-1:0]         held_reg, held_cur, held_dec, held_next;

    // Context of the current byte.
    logic                                 paged;
    logic                                 mapped;
    logic                                 run_dec;
    logic                                 comp;
    logic                                 blk_comp;
    logic [OFF_W-1:0]                     len;
    logic [OFF_W-1:0]                     room;
    logic [z80sbd_pkg::CNT_W-1:0]         run_cnt;
    logic [z80sbd_pkg::ADDR_W-1:0]        base;
    logic [z80sbd_pkg::ADDR_W-1:0]        base_map;
    logic [z80sbd_pkg::PAGE_NUM_W-1:0]    page_rel;
    logic [z80sbd_pkg::ADDR_W-1:0]        addr_off;
    logic [z80sbd_pkg::ADDR_W-1:0]        addr_dec;

    // Decoder results.
    z80sbd_pkg::fill_t                    dec_lo, dec_hi, fin_lo;
    logic [1:0]                           dec_n, fin_n;

    function automatic z80sbd_pkg::fill_t lit_fill(
        input logic [z80sbd_pkg::ADDR_W-1:0] addr,
        input logic [z80sbd_pkg::DATA_W-1:0] value
    );
        z80sbd_pkg::fill_t f;
        f.addr  = addr;
        f.value = value;
        f.count = z80sbd_pkg::CNT_W'(1);
        return f;
    endfunction

    // A start request clears the decoding state before the byte is used.
    always_comb begin
        hdr_cur  = start_req ? z80sbd_pkg::HDR_LEN_LO : hdr_reg;
        esc_cur  = start_req ? z80sbd_pkg::ESC_IDLE : esc_reg;
        blen_cur = start_req ? '0 : blen_reg;
        page_cur = start_req ? '0 : page_reg;
        cons_cur = start_req ? '0 : cons_reg;
        off_cur  = start_req ? '0 : off_reg;
        held_cur = start_req ? '0 : held_reg;
    end

    // Page mapping and the length, base and compression that apply to this byte.
    always_comb begin
        page_rel = page_cur - z80sbd_pkg::MAP128_FIRST;
        base_map = '0;
        mapped   = 1'b0;
        if (format_mode == z80sbd_pkg::FMT_PAGED48) begin
            if (page_cur == z80sbd_pkg::MAP48_PAGE4) begin
                base_map = z80sbd_pkg::MAP48_BASE4;
                mapped   = 1'b1;
            end else if (page_cur == z80sbd_pkg::MAP48_PAGE5) begin
                base_map = z80sbd_pkg::MAP48_BASE5;
                mapped   = 1'b1;
            end else if (page_cur == z80sbd_pkg::MAP48_PAGE8) begin
                base_map = z80sbd_pkg::MAP48_BASE8;
                mapped   = 1'b1;
            end
        end else if (page_cur >= z80sbd_pkg::MAP128_FIRST &&
                     page_cur <= z80sbd_pkg::MAP128_LAST) begin
            base_map = z80sbd_pkg::ADDR_W'(page_rel[2:0]) * PAGE_STEP;
            mapped   = 1'b1;
        end

        paged    = (format_mode != z80sbd_pkg::FMT_SINGLE);
        blk_comp = (blen_cur != z80sbd_pkg::RAW_MARK);
        if (!paged) begin
            run_dec = 1'b1;
            base    = z80sbd_pkg::SINGLE_BASE;
            len     = SINGLE_LEN;
            comp    = compressed;
        end else begin
            run_dec = (hdr_cur == z80sbd_pkg::HDR_DATA) && mapped;
            base    = base_map;
            len     = PAGE_LEN;
            comp    = blk_comp;
        end
        room     = len - off_cur;
        run_cnt  = (OFF_W'(held_cur) > room) ? room[z80sbd_pkg::CNT_W-1:0] : held_cur;
        addr_off = base + z80sbd_pkg::ADDR_W'(off_cur);
    end

    // Byte decoder: literals and ED ED count value runs, clipped at the area end.
    always_comb begin
        off_dec  = off_cur;
        esc_dec  = esc_cur;
        held_dec = held_cur;
        dec_lo   = lit_fill(addr_off, data_byte);
        dec_hi   = lit_fill(addr_off + z80sbd_pkg::ADDR_W'(1), data_byte);
        dec_n    = 2'd0;
        if (run_dec && off_cur < len) begin
            if (!comp) begin
                off_dec = off_cur + OFF_W'(1);
                dec_n   = 2'd1;
            end else begin
                unique case (esc_cur)
                    z80sbd_pkg::ESC_ONE: begin
                        if (data_byte == z80sbd_pkg::ESC_BYTE) begin
                            esc_dec = z80sbd_pkg::ESC_TWO;
                        end else begin
                            // The held ED was a literal; the byte follows it if room.
                            esc_dec = z80sbd_pkg::ESC_IDLE;
                            dec_lo  = lit_fill(addr_off, z80sbd_pkg::ESC_BYTE);
                            if (room >= OFF_W'(2)) begin
                                off_dec = off_cur + OFF_W'(2);
                                dec_n   = 2'd2;
                            end else begin
                                off_dec = off_cur + OFF_W'(1);
                                dec_n   = 2'd1;
                            end
                        end
                    end
                    z80sbd_pkg::ESC_TWO: begin
                        held_dec = data_byte;
                        esc_dec  = z80sbd_pkg::ESC_VALUE;
                    end
                    z80sbd_pkg::ESC_VALUE: begin
                        esc_dec = z80sbd_pkg::ESC_IDLE;
                        if (run_cnt != '0) begin
                            dec_lo.count = run_cnt;
                            off_dec      = off_cur + OFF_W'(run_cnt);
                            dec_n        = 2'd1;
                        end
                    end
                    z80sbd_pkg::ESC_IDLE: begin
                        if (data_byte == z80sbd_pkg::ESC_BYTE && room >= OFF_W'(2)) begin
                            esc_dec = z80sbd_pkg::ESC_ONE;
                        end else begin
                            off_dec = off_cur + OFF_W'(1);
                            dec_n   = 2'd1;
                        end
                    end
                endcase
            end
        end
    end

    // Block header sequencer and end-of-block handling.
    always_comb begin
        hdr_next  = hdr_cur;
        blen_next = blen_cur;
        page_next = page_cur;
        cons_next = cons_cur;
        off_next  = off_dec;
        esc_next  = esc_dec;
        held_next = held_dec;
        fin_lo    = dec_lo;
        fin_n     = dec_n;
        cons_inc  = cons_cur + z80sbd_pkg::CONS_W'(1);
        eff_len   = blk_comp ? z80sbd_pkg::CONS_W'(blen_cur) : RAW_LEN;
        addr_dec  = base + z80sbd_pkg::ADDR_W'(off_dec);
        if (paged) begin
            unique case (hdr_cur)
                z80sbd_pkg::HDR_LEN_LO: begin
                    blen_next = {8'h00, data_byte};
                    hdr_next  = z80sbd_pkg::HDR_LEN_HI;
                end
                z80sbd_pkg::HDR_LEN_HI: begin
                    blen_next = {data_byte, blen_cur[7:0]};
                    hdr_next  = z80sbd_pkg::HDR_PAGE;
                end
                z80sbd_pkg::HDR_PAGE: begin
                    page_next = data_byte;
                    cons_next = '0;
                    off_next  = '0;
                    esc_next  = z80sbd_pkg::ESC_IDLE;
                    held_next = '0;
                    hdr_next  = (blen_cur == '0) ? z80sbd_pkg::HDR_LEN_LO
                                                 : z80sbd_pkg::HDR_DATA;
                end
                z80sbd_pkg::HDR_DATA: begin
                    cons_next = cons_inc;
                    if (cons_inc >= eff_len) begin
                        // A lone ED left at the block end is written as a literal.
                        if (mapped && esc_dec == z80sbd_pkg::ESC_ONE && off_dec < len) begin
                            fin_lo   = lit_fill(addr_dec, z80sbd_pkg::ESC_BYTE);
                            off_next = off_dec + OFF_W'(1);
                            fin_n    = 2'd1;
                        end
                        esc_next = z80sbd_pkg::ESC_IDLE;
                        hdr_next = z80sbd_pkg::HDR_LEN_LO;
                    end
                end
            endcase
        end
        res_valid = (fin_n != 2'd0);
        res.lo    = fin_lo;
        res.hi    = dec_hi;
        res.two   = (fin_n == 2'd2);
    end

    // State registers, updated on each accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg  <= z80sbd_pkg::HDR_LEN_LO;
            esc_reg  <= z80sbd_pkg::ESC_IDLE;
            blen_reg <= '0;
            page_reg <= '0;
            cons_reg <= '0;
            off_reg  <= '0;
            held_reg <= '0;
        end else if (accept) begin
            hdr_reg  <= hdr_next;
            esc_reg  <= esc_next;
            blen_reg <= blen_next;
            page_reg <= page_next;
            cons_reg <= cons_next;
            off_reg  <= off_next;
            held_reg <= held_next;
        end
    end

endmodule

// ===== hdl/z80_snapshot_block_decoder.sv =====
// An accepted byte's fills are stored in the result queue before they reach the result port.
// One byte per cycle while s_ready is high; a byte that gives two fills presents them
// in turn, and a two-entry result queue keeps input and output decoupled.
// s_ready falls only while both result queue entries are occupied.
// Reset (aresetn low, synchronous): decoding state and the result queue are cleared,
// and the configuration returns to paged 48K map with compression enabled.
module z80_snapshot_block_decoder #(
    parameter int PAGE_BYTES         = 16384,
    parameter int SINGLE_BLOCK_BYTES = 49152
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // Configuration write port
    input  logic                                    cfg_wr_en,
    input  logic [z80sbd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [z80sbd_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    // Input byte stream
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [z80sbd_pkg::DATA_W-1:0]           s_data_byte,
    input  logic                                    s_start_req,
    // Memory fill results
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [z80sbd_pkg::ADDR_W-1:0]           m_write_address,
    output logic [z80sbd_pkg::DATA_W-1:0]           m_write_value,
    output logic [z80sbd_pkg::CNT_W-1:0]            m_repeat_count,
    output logic                                    m_last
);

    logic [1:0]                 fmt_reg;
    logic                       comp_reg;
    logic                       s_accept;
    logic                       res_valid;
    z80sbd_pkg::fill_pair_t     res;
    z80sbd_pkg::fill_pair_t     q_reg [2];
    z80sbd_pkg::fill_pair_t     head;
    z80sbd_pkg::fill_t          head_fill;
    logic                       wr_ptr_reg, wr_ptr_next;
    logic                       rd_ptr_reg, rd_ptr_next;
    logic                       sel_reg, sel_next;
    logic [1:0]                 count_reg, count_next;
    logic                       push;
    logic                       pop;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg  <= z80sbd_pkg::FMT_PAGED48;
            comp_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                z80sbd_pkg::REG_FORMAT_MODE: fmt_reg  <= cfg_wr_data;
                z80sbd_pkg::REG_COMPRESSED:  comp_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    assign s_ready  = (count_reg != 2'd2);
    assign s_accept = s_valid && s_ready;

    z80sbd_decode #(
        .PAGE_BYTES         (PAGE_BYTES),
        .SINGLE_BLOCK_BYTES (SINGLE_BLOCK_BYTES)
    ) u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .format_mode (fmt_reg),
        .compressed  (comp_reg),
        .accept      (s_accept),
        .data_byte   (s_data_byte),
        .start_req   (s_start_req),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Result queue head and the fill presented from it.
    assign head      = q_reg[rd_ptr_reg];
    assign head_fill = sel_reg ? head.hi : head.lo;

    assign m_valid         = (count_reg != 2'd0);
    assign m_write_address = head_fill.addr;
    assign m_write_value   = head_fill.value;
    assign m_repeat_count  = head_fill.count;
    assign m_last          = !head.two || sel_reg;

    assign push = s_accept && res_valid;
    assign pop  = m_valid && m_ready && m_last;

    // Queue pointer and occupancy bookkeeping.
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        sel_next    = sel_reg;
        if (m_valid && m_ready) begin
            sel_next = !m_last;
        end
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            sel_reg    <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            sel_reg    <= sel_next;
            count_reg  <= count_next;
        end
    end

    // Queue payload storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

// ===== hdl/z80sbd_checker.sv =====
module z80sbd_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic [z80sbd_pkg::ADDR_W-1:0]        m_write_address,
    input logic [z80sbd_pkg::DATA_W-1:0]        m_write_value,
    input logic [z80sbd_pkg::CNT_W-1:0]         m_repeat_count,
    input logic                                 m_last
);

    // No result is presented, and the input is open, in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> (!m_valid && s_ready))
        else $error("result valid or input closed straight after reset");

    // A fill always covers at least one address.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_repeat_count != '0)
        else $error("fill with zero repeat count");

    // The second fill of a byte follows the first without a gap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> m_valid)
        else $error("second fill of a byte missing");

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_write_address) &&
            $stable(m_write_value) && $stable(m_repeat_count) && $stable(m_last)))
        else $error("stalled result changed");

endmodule

bind z80_snapshot_block_decoder z80sbd_checker u_z80sbd_checker (.*);

// ===== tb/tb_z80_snapshot_block_decoder.sv =====
module tb_z80_snapshot_block_decoder;

    localparam int unsigned PAGE_LEN         = 16384;
    localparam int unsigned SINGLE_LEN       = 49152;
    localparam logic [1:0]  FMT_SPARE        = 2'd3;
    localparam int          PHASE_ITEMS      = 120;
    localparam int          NUM_PHASES       = 9;
    localparam int          FILL_RUNS_PAGE   = PAGE_LEN / 255;
    localparam int          FILL_RUNS_SINGLE = SINGLE_LEN / 255;
    localparam int          SETTLE_CYCLES    = 4;
    localparam longint      RUN_LIMIT        = 64'd1_500_000;

    // Directed stream: a run, a zero-count run with a trailing lone escape, an empty block,
    // an unmapped block cut short by a start request, then an escape followed by a literal.
    localparam int DIRECTED_RESTART = 23;
    localparam logic [7:0] DIRECTED [28] = '{
        8'h05, 8'h00, z80sbd_pkg::MAP48_PAGE8, 8'h00,
        z80sbd_pkg::ESC_BYTE, z80sbd_pkg::ESC_BYTE, 8'h03, 8'hFF,
        8'h05, 8'h00, z80sbd_pkg::MAP48_PAGE4, z80sbd_pkg::ESC_BYTE,
        z80sbd_pkg::ESC_BYTE, 8'h00, 8'h55, z80sbd_pkg::ESC_BYTE,
        8'h00, 8'h00, z80sbd_pkg::MAP48_PAGE5,
        8'h02, 8'h00, 8'h09, 8'h01,
        8'h02, 8'h00, z80sbd_pkg::MAP48_PAGE5, z80sbd_pkg::ESC_BYTE, 8'h41
    };

    // Register settings visited by the random part, one per phase.
    localparam logic [1:0] PH_FMT [NUM_PHASES] = '{
        z80sbd_pkg::FMT_PAGED128, z80sbd_pkg::FMT_SINGLE, z80sbd_pkg::FMT_PAGED48,
        FMT_SPARE, z80sbd_pkg::FMT_SINGLE, z80sbd_pkg::FMT_PAGED128,
        z80sbd_pkg::FMT_PAGED48, z80sbd_pkg::FMT_SINGLE, z80sbd_pkg::FMT_PAGED128
    };
    localparam bit PH_COMP  [NUM_PHASES] = '{1, 1, 0, 1, 0, 0, 1, 1, 1};
    localparam bit PH_START [NUM_PHASES] = '{1, 1, 1, 1, 1, 0, 1, 0, 1};

    typedef struct packed {
        z80sbd_pkg::fill_t f;
        logic              last;
    } fill_exp_t;

    typedef struct packed {
        logic [z80sbd_pkg::DATA_W-1:0] b;
        logic                          st;
    } byte_item_t;

    // Predicts the fills of every accepted byte and checks the fills that come out.
    class fill_tracker;
        logic [1:0]                        fmt;
        logic                              comp_cfg;
        z80sbd_pkg::hdr_phase_t            hdr;
        logic [z80sbd_pkg::LEN_W-1:0]      blk_len;
        logic [z80sbd_pkg::PAGE_NUM_W-1:0] page;
        int unsigned                       consumed;
        int unsigned                       offset;
        z80sbd_pkg::esc_phase_t            esc;
        logic [7:0]                        held;
        fill_exp_t                         batch[$];
        fill_exp_t                         due_fills[$];
        int unsigned                       errors;

        function new();
            fmt = z80sbd_pkg::FMT_PAGED48;
            comp_cfg = 1'b1;
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            hdr = z80sbd_pkg::HDR_LEN_LO;
            blk_len = '0;
            page = '0;
            consumed = 0;
            offset = 0;
            esc = z80sbd_pkg::ESC_IDLE;
            held = '0;
        endfunction

        function void push_fill(input int unsigned addr, input logic [7:0] value,
                                input int unsigned count);
            fill_exp_t r;
            r.f.addr = addr[z80sbd_pkg::ADDR_W-1:0];
            r.f.value = value;
            r.f.count = count[z80sbd_pkg::CNT_W-1:0];
            r.last = 1'b0;
            batch.push_back(r);
        endfunction

        // The 48K map knows three pages; any other mode uses the 128K map.
        function bit page_base(output int unsigned base);
            base = 0;
            if (fmt == z80sbd_pkg::FMT_PAGED48) begin
                if (page == z80sbd_pkg::MAP48_PAGE4) begin
                    base = z80sbd_pkg::MAP48_BASE4;
                    return 1'b1;
                end
                if (page == z80sbd_pkg::MAP48_PAGE5) begin
                    base = z80sbd_pkg::MAP48_BASE5;
                    return 1'b1;
                end
                if (page == z80sbd_pkg::MAP48_PAGE8) begin
                    base = z80sbd_pkg::MAP48_BASE8;
                    return 1'b1;
                end
                return 1'b0;
            end
            if (page >= z80sbd_pkg::MAP128_FIRST && page <= z80sbd_pkg::MAP128_LAST) begin
                base = (page - z80sbd_pkg::MAP128_FIRST) * PAGE_LEN;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void write_literal(input int unsigned base, input int unsigned len,
                                    input logic [7:0] b);
            if (offset >= len)
                return;
            push_fill(base + offset, b, 1);
            offset++;
        endfunction

        // One data byte through the run-length escape sequencer.
        function void decode_data(input logic [7:0] b, input int unsigned base,
                                  input int unsigned len, input bit comp);
            int unsigned room;
            int unsigned cnt;
            if (offset >= len)
                return;
            if (!comp) begin
                write_literal(base, len, b);
                return;
            end
            case (esc)
                z80sbd_pkg::ESC_ONE: begin
                    if (b == z80sbd_pkg::ESC_BYTE) begin
                        esc = z80sbd_pkg::ESC_TWO;
                        return;
                    end
                    esc = z80sbd_pkg::ESC_IDLE;
                    write_literal(base, len, z80sbd_pkg::ESC_BYTE);
                    if (offset >= len)
                        return;
                end
                z80sbd_pkg::ESC_TWO: begin
                    held = b;
                    esc = z80sbd_pkg::ESC_VALUE;
                    return;
                end
                z80sbd_pkg::ESC_VALUE: begin
                    esc = z80sbd_pkg::ESC_IDLE;
                    cnt = held;
                    room = len - offset;
                    if (cnt > room)
                        cnt = room;
                    if (cnt != 0) begin
                        push_fill(base + offset, b, cnt);
                        offset += cnt;
                    end
                    return;
                end
                default: ;
            endcase
            // An escape byte only opens a run while two or more bytes of room remain.
            if (b == z80sbd_pkg::ESC_BYTE && len - offset >= 2) begin
                esc = z80sbd_pkg::ESC_ONE;
                return;
            end
            write_literal(base, len, b);
        endfunction

        function void take_byte(input logic [7:0] b, input logic st);
            int unsigned base;
            int unsigned eff_len;
            bit mapped;
            bit comp;
            batch.delete();
            if (st)
                clear_state();
            if (fmt == z80sbd_pkg::FMT_SINGLE) begin
                decode_data(b, z80sbd_pkg::SINGLE_BASE, SINGLE_LEN, comp_cfg);
            end else begin
                case (hdr)
                    z80sbd_pkg::HDR_LEN_LO: begin
                        blk_len = {8'h00, b};
                        hdr = z80sbd_pkg::HDR_LEN_HI;
                    end
                    z80sbd_pkg::HDR_LEN_HI: begin
                        blk_len = {b, blk_len[7:0]};
                        hdr = z80sbd_pkg::HDR_PAGE;
                    end
                    z80sbd_pkg::HDR_PAGE: begin
                        page = b;
                        consumed = 0;
                        offset = 0;
                        esc = z80sbd_pkg::ESC_IDLE;
                        held = '0;
                        hdr = (blk_len == 0) ? z80sbd_pkg::HDR_LEN_LO : z80sbd_pkg::HDR_DATA;
                    end
                    default: begin
                        comp = (blk_len != z80sbd_pkg::RAW_MARK);
                        eff_len = comp ? blk_len : PAGE_LEN;
                        mapped = page_base(base);
                        consumed++;
                        if (mapped)
                            decode_data(b, base, PAGE_LEN, comp);
                        // At the end of a block a lone pending escape becomes a literal.
                        if (consumed >= eff_len) begin
                            if (mapped && esc == z80sbd_pkg::ESC_ONE)
                                write_literal(base, PAGE_LEN, z80sbd_pkg::ESC_BYTE);
                            esc = z80sbd_pkg::ESC_IDLE;
                            hdr = z80sbd_pkg::HDR_LEN_LO;
                        end
                    end
                endcase
            end
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i])
                due_fills.push_back(batch[i]);
        endfunction

        function void check_field(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_fill(input fill_exp_t got);
            fill_exp_t want;
            if (due_fills.size() == 0) begin
                $display("%0t: fill mismatch: expected none, actual %0h %0h %0d %b",
                         $time, got.f.addr, got.f.value, got.f.count, got.last);
                errors++;
                return;
            end
            want = due_fills.pop_front();
            check_field("write_address", want.f.addr, got.f.addr);
            check_field("write_value", want.f.value, got.f.value);
            check_field("repeat_count", want.f.count, got.f.count);
            check_field("last", want.last, got.last);
        endfunction
    endclass

    logic                              aclk;
    logic                              aresetn;
    logic                              cfg_wr_en;
    logic [z80sbd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [z80sbd_pkg::CFG_DATA_W-1:0] cfg_wr_data;
    logic                              s_valid;
    logic                              s_ready;
    logic [z80sbd_pkg::DATA_W-1:0]     s_data_byte;
    logic                              s_start_req;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic [z80sbd_pkg::ADDR_W-1:0]     m_write_address;
    logic [z80sbd_pkg::DATA_W-1:0]     m_write_value;
    logic [z80sbd_pkg::CNT_W-1:0]      m_repeat_count;
    logic                              m_last;

    fill_tracker tracker;
    byte_item_t  stream[$];
    bit          need_start;
    int          src_idle_pct;
    int          snk_idle_pct;

    z80_snapshot_block_decoder #(
        .PAGE_BYTES        (PAGE_LEN),
        .SINGLE_BLOCK_BYTES(SINGLE_LEN)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_start_req    (s_start_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_write_address(m_write_address),
        .m_write_value  (m_write_value),
        .m_repeat_count (m_repeat_count),
        .m_last         (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Result side: check every accepted transaction and stall at random.
    always @(posedge aclk) begin
        fill_exp_t got;
        if (aresetn && m_valid && m_ready) begin
            got.f.addr = m_write_address;
            got.f.value = m_write_value;
            got.f.count = m_repeat_count;
            got.last = m_last;
            tracker.check_fill(got);
        end
        m_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom);
    endfunction

    // Appends a byte; the pending start request, if any, goes with it.
    function automatic void put(input logic [7:0] b);
        byte_item_t it;
        it.b = b;
        it.st = need_start;
        need_start = 1'b0;
        stream.push_back(it);
    endfunction

    function automatic logic [7:0] run_count();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(254, 1));
        endcase
    endfunction

    // Random data of at least n bytes: literals, plus runs and lone escapes when comp is set.
    function automatic void add_body(input int n, input bit comp);
        int s0;
        int r;
        s0 = stream.size();
        while (stream.size() - s0 < n) begin
            r = $urandom_range(9);
            if (!comp || r < 5) begin
                put(rnd_byte());
            end else if (r < 8) begin
                put(z80sbd_pkg::ESC_BYTE);
                put(z80sbd_pkg::ESC_BYTE);
                put(run_count());
                put(rnd_byte());
            end else begin
                put(z80sbd_pkg::ESC_BYTE);
            end
        end
    endfunction

    // An optional tail that stops a block part way through an escape sequence.
    function automatic void add_escape_tail();
        int k;
        k = $urandom_range(3);
        if (k >= 1)
            put(z80sbd_pkg::ESC_BYTE);
        if (k >= 2)
            put(z80sbd_pkg::ESC_BYTE);
        if (k >= 3)
            put(run_count());
    endfunction

    // Full-length runs up to just short of the end, then a run that may be clipped and a
    // few escapes and literals around the last addresses.
    function automatic void area_fill(input int runs, input int unsigned cap);
        int rest;
        repeat (runs) begin
            put(z80sbd_pkg::ESC_BYTE);
            put(z80sbd_pkg::ESC_BYTE);
            put(8'd255);
            put(rnd_byte());
        end
        rest = cap - runs * 255;
        put(z80sbd_pkg::ESC_BYTE);
        put(z80sbd_pkg::ESC_BYTE);
        put(8'(rest - 4 + $urandom_range(5)));
        put(rnd_byte());
        repeat (6)
            put($urandom_range(1) ? z80sbd_pkg::ESC_BYTE : rnd_byte());
    endfunction

    function automatic logic [7:0] mapped_page();
        if (tracker.fmt == z80sbd_pkg::FMT_PAGED48) begin
            case ($urandom_range(2))
                0: return z80sbd_pkg::MAP48_PAGE4;
                1: return z80sbd_pkg::MAP48_PAGE5;
                default: return z80sbd_pkg::MAP48_PAGE8;
            endcase
        end
        return 8'(z80sbd_pkg::MAP128_FIRST +
                  $urandom_range(z80sbd_pkg::MAP128_LAST - z80sbd_pkg::MAP128_FIRST));
    endfunction

    function automatic logic [7:0] unmapped_page();
        logic [7:0] p;
        do begin
            p = rnd_byte();
        end while (tracker.fmt == z80sbd_pkg::FMT_PAGED48 ?
                   (p == z80sbd_pkg::MAP48_PAGE4 || p == z80sbd_pkg::MAP48_PAGE5 ||
                    p == z80sbd_pkg::MAP48_PAGE8) :
                   (p >= z80sbd_pkg::MAP128_FIRST && p <= z80sbd_pkg::MAP128_LAST));
        return p;
    endfunction

    // One paged block; the length bytes are patched once the body is known.
    function automatic void paged_block();
        int kind;
        int h;
        int s0;
        logic [15:0] decl;
        bit broken;
        kind = $urandom_range(99);
        broken = 1'b0;
        h = stream.size();
        put(8'h00);
        put(8'h00);
        put(kind < 8 ? unmapped_page() : mapped_page());
        s0 = stream.size();
        decl = 16'(0);
        if (kind < 8) begin
            add_body($urandom_range(30, 1), 1'b1);
        end else if (kind < 13) begin
            // Empty block: the header alone.
        end else if (kind < 17) begin
            area_fill(FILL_RUNS_PAGE, PAGE_LEN);
        end else if (kind < 25) begin
            // Raw block abandoned by a start request.
            repeat ($urandom_range(40, 5))
                put(rnd_byte());
            broken = 1'b1;
        end else if (kind < 33) begin
            add_body($urandom_range(40, 1), 1'b1);
            broken = 1'b1;
        end else if (kind < 40) begin
            repeat ($urandom_range(20, 3)) begin
                need_start = ($urandom_range(7) == 0);
                put(rnd_byte());
            end
            broken = 1'b1;
        end else begin
            add_body($urandom_range(40, 1), 1'b1);
            if ($urandom_range(3) == 0)
                add_escape_tail();
        end
        decl = 16'(stream.size() - s0);
        if (kind >= 17 && kind < 25)
            decl = z80sbd_pkg::RAW_MARK;
        else if (broken)
            decl = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(60, 1));
        stream[h].b = decl[7:0];
        stream[h + 1].b = decl[15:8];
        if (broken)
            need_start = 1'b1;
    endfunction

    function automatic void single_stream(input bit full);
        if ($urandom_range(2) == 0)
            need_start = 1'b1;
        if (full) begin
            need_start = 1'b1;
            area_fill(FILL_RUNS_SINGLE, SINGLE_LEN);
            repeat (5)
                put(rnd_byte());
        end else begin
            add_body($urandom_range(60, 10), tracker.comp_cfg);
            if ($urandom_range(3) == 0)
                add_escape_tail();
        end
    endfunction

    // Offers one byte, with a random gap before it, and notes it once accepted.
    task automatic send_byte(input byte_item_t it);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= it.b;
        s_start_req <= it.st;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        tracker.take_byte(it.b, it.st);
    endtask

    task automatic play_stream();
        while (stream.size() != 0)
            send_byte(stream.pop_front());
    endtask

    // Waits for every expected fill, then lets the block settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.due_fills.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES)
            @(posedge aclk);
    endtask

    // Both registers in consecutive cycles, with the write enable held high throughout.
    task automatic apply_setting(input logic [1:0] fmt, input logic comp);
        cfg_wr_en <= 1'b1;
        cfg_index <= z80sbd_pkg::REG_FORMAT_MODE;
        cfg_wr_data <= fmt;
        @(posedge aclk);
        cfg_index <= z80sbd_pkg::REG_COMPRESSED;
        cfg_wr_data <= {1'b0, comp};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.fmt = fmt;
        tracker.comp_cfg = comp;
    endtask

    initial begin
        int sent;
        tracker = new();
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= z80sbd_pkg::REG_FORMAT_MODE;
        cfg_wr_data <= '0;
        s_valid <= 1'b0;
        s_data_byte <= '0;
        s_start_req <= 1'b0;
        src_idle_pct = 12;
        snk_idle_pct = 53;
        repeat (8)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed stream under the reset configuration.
        foreach (DIRECTED[i]) begin
            need_start = (i == 0 || i == DIRECTED_RESTART);
            put(DIRECTED[i]);
        end
        play_stream();
        drain();

        // Random phases, each under its own register setting.
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 3) begin
                src_idle_pct = 53;
                snk_idle_pct = 12;
            end else if (p == 6) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            apply_setting(PH_FMT[p], PH_COMP[p]);
            need_start = PH_START[p];
            sent = 0;
            if (p == 1) begin
                single_stream(1'b1);
                sent = stream.size();
                play_stream();
            end
            while (sent < PHASE_ITEMS) begin
                if (tracker.fmt == z80sbd_pkg::FMT_SINGLE)
                    single_stream(1'b0);
                else
                    paged_block();
                sent += stream.size();
                play_stream();
            end
            drain();
        end

        if (tracker.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(RUN_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/z80sbd_pkg.sv
hdl/z80sbd_decode.sv
hdl/z80_snapshot_block_decoder.sv
hdl/z80sbd_checker.sv
tb/tb_z80_snapshot_block_decoder.sv
